// ===== src/srec_pkg.sv =====
// Shared types, character codes and hex decode for the S-record loader.
package srec_pkg;

  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;
  localparam logic [7:0] ALPHA_LO  = 8'h41;
  localparam logic [7:0] ALPHA_HI  = 8'h46;
  localparam logic [7:0] ALPHA_OFS = 8'h37;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    EV_WRITE = 2'd0,
    EV_GOOD  = 2'd1,
    EV_ERROR = 2'd2,
    EV_END   = 2'd3
  } ev_kind_e;

  typedef enum logic [11:0] {
    PH_IDLE  = 12'b0000_0000_0001,
    PH_GOT_S = 12'b0000_0000_0010,
    PH_CNT_H = 12'b0000_0000_0100,
    PH_CNT_L = 12'b0000_0000_1000,
    PH_AH_H  = 12'b0000_0001_0000,
    PH_AH_L  = 12'b0000_0010_0000,
    PH_AL_H  = 12'b0000_0100_0000,
    PH_AL_L  = 12'b0000_1000_0000,
    PH_D_H   = 12'b0001_0000_0000,
    PH_D_L   = 12'b0010_0000_0000,
    PH_CK_H  = 12'b0100_0000_0000,
    PH_CK_L  = 12'b1000_0000_0000
  } phase_e;

  // Upper-case hex only; anything else reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c inside {[DIGIT_LO:DIGIT_HI]}) begin
      diff = c - DIGIT_LO;
    end else if (c inside {[ALPHA_LO:ALPHA_HI]}) begin
      diff = c - ALPHA_OFS;
    end
    return diff[3:0];
  endfunction

endpackage

// ===== src/srec_stream_if.sv =====
// Valid/ready channels: received characters in, loader events out.
interface srec_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface srec_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [15:0] record_number;

  modport source (output valid, output event_kind, output write_address,
                  output write_data, output record_number, input ready);
  modport sink   (input valid, input event_kind, input write_address,
                  input write_data, input record_number, output ready);
endinterface

// ===== src/srecord_s1_loader_unit.sv =====
// S1/S9 S-record parser: one character per word in, at most one event per word out.
// An event is registered: it is on the output register the cycle after its character.
// Throughput: one character per cycle when not stalled; parse state updates per character.
// Input stalls only while the output register holds an event not yet taken.
// Reset (async, active low) clears parse state, counters, stop flag and output valid.
module srecord_s1_loader_unit
  import srec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  srec_char_if.sink    rx_i,
  srec_event_if.source ev_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  hi_q, hi_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] good_q, good_d;
  logic        stop_q, stop_d;

  logic        out_valid_q;
  ev_kind_e    kind_q, kind_d;
  logic [15:0] waddr_q, waddr_d;
  logic [7:0]  wdata_q, wdata_d;
  logic [15:0] num_q, num_d;
  logic        emit;

  logic        accept;
  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  left_dec;
  logic [7:0]  sum_add;
  logic [15:0] good_inc;

  assign rx_i.ready = !out_valid_q || ev_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  assign nib      = hex_value(rx_i.rx_char);
  assign byte_val = {hi_q, nib};
  assign left_dec = left_q - 8'd1;
  assign sum_add  = sum_q + byte_val;
  assign good_inc = (good_q != COUNT_MAX) ? good_q + 16'd1 : COUNT_MAX;

  always_comb begin
    phase_d = phase_q;
    hi_d    = hi_q;
    left_d  = left_q;
    addr_d  = addr_q;
    sum_d   = sum_q;
    good_d  = good_q;
    stop_d  = stop_q;
    emit    = 1'b0;
    kind_d  = EV_WRITE;
    waddr_d = 16'h0000;
    wdata_d = 8'h00;
    num_d   = 16'h0000;
    if (accept && !stop_q) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_i.rx_char == CHAR_S) phase_d = PH_GOT_S;
        end
        PH_GOT_S: begin
          if (rx_i.rx_char == CHAR_ONE) begin
            sum_d   = 8'h00;
            phase_d = PH_CNT_H;
          end else begin
            phase_d = PH_IDLE;
            if (rx_i.rx_char == CHAR_NINE) begin
              stop_d = 1'b1;
              emit   = 1'b1;
              kind_d = EV_END;
              num_d  = good_q;
            end
          end
        end
        PH_CNT_H: begin
          hi_d    = nib;
          phase_d = PH_CNT_L;
        end
        PH_AH_H: begin
          hi_d    = nib;
          phase_d = PH_AH_L;
        end
        PH_AL_H: begin
          hi_d    = nib;
          phase_d = PH_AL_L;
        end
        PH_D_H: begin
          hi_d    = nib;
          phase_d = PH_D_L;
        end
        PH_CK_H: begin
          hi_d    = nib;
          phase_d = PH_CK_L;
        end
        PH_CNT_L: begin
          // count covers the address and checksum bytes
          left_d  = (byte_val > 8'd3) ? byte_val - 8'd3 : 8'd0;
          sum_d   = sum_add;
          phase_d = PH_AH_H;
        end
        PH_AH_L: begin
          addr_d  = {byte_val, 8'h00};
          sum_d   = sum_add;
          phase_d = PH_AL_H;
        end
        PH_AL_L: begin
          addr_d  = {addr_q[15:8], byte_val};
          sum_d   = sum_add;
          phase_d = (left_q != 8'd0) ? PH_D_H : PH_CK_H;
        end
        PH_D_L: begin
          sum_d   = sum_add;
          addr_d  = addr_q + 16'd1;
          left_d  = left_dec;
          phase_d = (left_dec != 8'd0) ? PH_D_H : PH_CK_H;
          emit    = 1'b1;
          kind_d  = EV_WRITE;
          waddr_d = addr_q;
          wdata_d = byte_val;
        end
        PH_CK_L: begin
          phase_d = PH_IDLE;
          emit    = 1'b1;
          num_d   = good_inc;
          if (~sum_q == byte_val) begin
            good_d = good_inc;
            kind_d = EV_GOOD;
          end else begin
            stop_d = 1'b1;
            kind_d = EV_ERROR;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hi_q        <= 4'h0;
      left_q      <= 8'h00;
      addr_q      <= 16'h0000;
      sum_q       <= 8'h00;
      good_q      <= 16'h0000;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
      left_q  <= left_d;
      addr_q  <= addr_d;
      sum_q   <= sum_d;
      good_q  <= good_d;
      stop_q  <= stop_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (ev_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= kind_d;
      waddr_q <= waddr_d;
      wdata_q <= wdata_d;
      num_q   <= num_d;
    end
  end

  assign ev_o.valid         = out_valid_q;
  assign ev_o.event_kind    = kind_q;
  assign ev_o.write_address = waddr_q;
  assign ev_o.write_data    = wdata_q;
  assign ev_o.record_number = num_q;

endmodule

// ===== src/srec_checker.sv =====
// Port-level checks for the S-record loader, bound to the top level.
module srec_checker
  import srec_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  event_kind_i,
  input logic [15:0] write_address_i,
  input logic [7:0]  write_data_i,
  input logic [15:0] record_number_i
);

  logic out_accept;
  assign out_accept = out_valid_i && out_ready_i;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("event word dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(event_kind_i) && $stable(record_number_i)
      && $stable(write_address_i) && $stable(write_data_i))
    else $error("event word changed while stalled");

  // once an end or error word leaves, the loader stays silent
  a_quiet_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && (event_kind_i == EV_ERROR || event_kind_i == EV_END) |=> !out_valid_i)
    else $error("event after end or error");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i != EV_WRITE |-> write_address_i == 16'h0000
      && write_data_i == 8'h00)
    else $error("status word carries write fields");

  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == EV_WRITE |-> record_number_i == 16'h0000)
    else $error("write word carries a record number");

endmodule

bind srecord_s1_loader_unit srec_checker u_srec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (ev_o.valid),
  .out_ready_i     (ev_o.ready),
  .event_kind_i    (ev_o.event_kind),
  .write_address_i (ev_o.write_address),
  .write_data_i    (ev_o.write_data),
  .record_number_i (ev_o.record_number)
);

// ===== tb/sv/srec_loader_checker.sv =====
`timescale 1ns / 100ps
// Loader event checker: watches both channels, predicts events per character and compares.
module srec_loader_checker
  import srec_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  srec_char_if  chars_i,
  srec_event_if events_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    checked_o
);

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    ev_kind_e    kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [15:0] number;
  } loader_event_t;

  loader_event_t expected_events[$];

  // predicted parser state
  phase_e      phase     = PH_IDLE;
  logic [3:0]  hi_nib    = 4'h0;
  logic [7:0]  left      = 8'h00;
  logic [15:0] addr      = 16'h0000;
  logic [7:0]  sum       = 8'h00;
  logic [15:0] good      = 16'h0000;
  logic        halted    = 1'b0;

  int fail_count = 0;
  int queued     = 0;
  int checked    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = queued;
  assign checked_o    = checked;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
    return 4'h0;
  endfunction

  function automatic void queue_event(input ev_kind_e k, input logic [15:0] a,
                                      input logic [7:0] d, input logic [15:0] n);
    loader_event_t ev;
    ev.kind    = k;
    ev.address = a;
    ev.data    = d;
    ev.number  = n;
    expected_events.push_back(ev);
  endfunction

  task automatic parse_char(input logic [7:0] c);
    logic [3:0] nib;
    logic [7:0] val;
    nib = digit_value(c);
    val = {hi_nib, nib};
    if (!halted) begin
      case (phase)
        PH_IDLE: begin
          if (c == CHAR_S) phase = PH_GOT_S;
        end
        PH_GOT_S: begin
          if (c == CHAR_ONE) begin
            sum   = 8'h00;
            phase = PH_CNT_H;
          end else begin
            phase = PH_IDLE;
            if (c == CHAR_NINE) begin
              halted = 1'b1;
              queue_event(EV_END, 16'h0000, 8'h00, good);
            end
          end
        end
        PH_CNT_H, PH_AH_H, PH_AL_H, PH_D_H, PH_CK_H: begin
          hi_nib = nib;
          // one-hot phases: the low-digit phase is the next bit up
          phase  = phase_e'({phase[10:0], 1'b0});
        end
        PH_CNT_L: begin
          left  = (val > 8'd3) ? val - 8'd3 : 8'd0;
          sum   = sum + val;
          phase = PH_AH_H;
        end
        PH_AH_L: begin
          addr  = {val, 8'h00};
          sum   = sum + val;
          phase = PH_AL_H;
        end
        PH_AL_L: begin
          addr[7:0] = val;
          sum       = sum + val;
          phase     = (left != 8'd0) ? PH_D_H : PH_CK_H;
        end
        PH_D_L: begin
          queue_event(EV_WRITE, addr, val, 16'h0000);
          sum   = sum + val;
          addr  = addr + 16'd1;
          left  = left - 8'd1;
          phase = (left != 8'd0) ? PH_D_H : PH_CK_H;
        end
        PH_CK_L: begin
          phase = PH_IDLE;
          if (~sum == val) begin
            if (good != COUNT_MAX) good = good + 16'd1;
            queue_event(EV_GOOD, 16'h0000, 8'h00, good);
          end else begin
            halted = 1'b1;
            queue_event(EV_ERROR, 16'h0000, 8'h00,
                        (good != COUNT_MAX) ? good + 16'd1 : COUNT_MAX);
          end
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    else if (fail_count == PRINT_CAP) $display("%0t further mismatches counted only", $time);
    fail_count++;
  endtask

  task automatic check_event();
    loader_event_t want;
    checked++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event kind %0d with nothing pending", events_i.event_kind));
    end else begin
      want = expected_events.pop_front();
      if (events_i.event_kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", events_i.event_kind, want.kind));
      if (events_i.write_address !== want.address)
        report_mismatch($sformatf("address %h, want %h", events_i.write_address,
                                  want.address));
      if (events_i.write_data !== want.data)
        report_mismatch($sformatf("data %h, want %h", events_i.write_data, want.data));
      if (events_i.record_number !== want.number)
        report_mismatch($sformatf("record number %0d, want %0d", events_i.record_number,
                                  want.number));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase  = PH_IDLE;
      hi_nib = 4'h0;
      left   = 8'h00;
      addr   = 16'h0000;
      sum    = 8'h00;
      good   = 16'h0000;
      halted = 1'b0;
      expected_events.delete();
      queued = 0;
    end else begin
      if (events_i.valid && events_i.ready) check_event();
      if (chars_i.valid && chars_i.ready) parse_char(chars_i.rx_char);
      queued = expected_events.size();
    end
  end

endmodule

// ===== tb/sv/srecord_s1_loader_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, character stimulus, event sink, watchdog and verdict.
module srecord_s1_loader_unit_tb
  import srec_pkg::*;
();

  localparam int HOLD_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CHARS   = 1550;
  localparam int BURST_FIRST    = 12;
  localparam int BURST_LAST     = 19;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  bit    idle_on;
  bit    hold_req;
  int    chars_sent   = 0;
  int    record_chars = 0;
  int    good_sent    = 0;
  int    fail_count;
  int    pending;
  int    checked;
  string ending;

  srec_char_if  char_ch ();
  srec_event_if event_ch ();

  srecord_s1_loader_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (char_ch),
    .ev_o   (event_ch)
  );

  srec_loader_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chars_i      (char_ch),
    .events_i     (event_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  // Call at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_char(input logic [7:0] c);
    while (idle_on && $urandom_range(0, 99) < 22) begin
      char_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    char_ch.valid   = 1'b1;
    char_ch.rx_char = c;
    @(posedge clk_i);
    while (!char_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [7:0] c;
    if (n == 4'd0 && $urandom_range(0, 7) == 0) begin
      // any character outside 0-9 and A-F reads as a zero digit
      do begin
        c = 8'($urandom_range(0, 255));
      end while ((c >= DIGIT_LO && c <= DIGIT_HI) || (c >= ALPHA_LO && c <= ALPHA_HI));
      return c;
    end
    return (n < 4'd10) ? DIGIT_LO + n : ALPHA_OFS + n;
  endfunction

  task automatic send_hex_byte(input logic [7:0] b);
    send_char(nibble_char(b[7:4]));
    send_char(nibble_char(b[3:0]));
  endtask

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'($urandom_range(0, 3));
    if (r < 97) return 8'($urandom_range(4, 24));
    return 8'($urandom_range(25, 255));
  endfunction

  function automatic logic [15:0] pick_address();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return 16'($urandom_range(16'hFFF0, 16'hFFFF));
    if (r == 2) return 16'h0000;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                             input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    n   = (count > 8'd3) ? count - 3 : 0;
    sum = count + addr[15:8] + addr[7:0];
    send_text("S1");
    send_hex_byte(count);
    send_hex_byte(addr[15:8]);
    send_hex_byte(addr[7:0]);
    repeat (n) begin
      b   = pick_data();
      sum = sum + b;
      send_hex_byte(b);
    end
    b = ~sum;
    if (corrupt) b = b ^ 8'($urandom_range(1, 255));
    send_hex_byte(b);
    record_chars += 10 + 2 * n;
    if (!corrupt) good_sent++;
  endtask

  // junk between records and aborted record starts
  task automatic send_noise();
    int         sel;
    logic [7:0] c;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      repeat ($urandom_range(1, 4)) begin
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_S) c = 8'h00;
        send_char(c);
      end
    end else if (sel < 5) begin
      send_char(CHAR_S);
      c = 8'($urandom_range(0, 255));
      if (c == CHAR_ONE || c == CHAR_NINE) c = CHAR_S;
      send_char(c);
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  // event sink: random stalls, plus one long hold on request
  initial begin
    event_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        event_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      event_ch.ready = !(idle_on && $urandom_range(0, 99) < 22);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((char_ch.valid && char_ch.ready) || (event_ch.valid && event_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int nrec;
    nrec            = 0;
    rst_ni          = 1'b0;
    char_ch.valid   = 1'b0;
    char_ch.rx_char = 8'h00;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    ending          = "";
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes while idle, aborted start, address wrap, lower-case digits
    send_char(8'h00);
    send_char(8'hFF);
    send_text("S7");
    send_text("S105FFFF00FFFD");
    send_text("S1031zb2EA");
    good_sent = 2;

    while (record_chars < RANDOM_CHARS) begin
      nrec++;
      // a run of records at full rate on both sides
      idle_on = !(nrec >= BURST_FIRST && nrec <= BURST_LAST);
      send_noise();
      if (nrec == 4) begin
        // largest record while the sink holds off: output fills, input stalls
        hold_req = 1'b1;
        send_record(8'hFF, pick_address(), 1'b0);
      end else begin
        send_record(pick_count(), pick_address(), 1'b0);
      end
      if (nrec == 8) begin
        char_ch.valid = 1'b0;
        wait_drained();
      end
    end
    idle_on = 1'b1;

    if ($urandom_range(0, 1)) begin
      ending = "checksum error";
      send_record(8'($urandom_range(4, 8)), pick_address(), 1'b1);
    end else begin
      ending = "S9 end record";
      send_text("S9030000FC");
    end
    // stopped: none of these may produce an event
    send_record(8'd6, pick_address(), 1'b0);
    send_noise();
    send_text("S9");
    char_ch.valid = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("summary: %0d characters taken, %0d good S1 records sent, %0d events checked",
             chars_sent, good_sent, checked);
    $display("summary: %0d-cycle sink hold, full-rate run over records %0d-%0d, closed by %s",
             HOLD_CYCLES, BURST_FIRST, BURST_LAST, ending);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/srec_pkg.sv
src/srec_stream_if.sv
src/srecord_s1_loader_unit.sv
src/srec_checker.sv
tb/sv/srec_loader_checker.sv
tb/sv/srecord_s1_loader_unit_tb.sv
